// ===== src/ual_pkg.sv =====
// Shared types and constants for the UART line assembler.
// No dependencies; imported by ual_line_mem and uart_line_assembler.
`default_nettype none

package ual_pkg;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_CLR_EVT = 2'd3
    } ual_op_t;

    localparam int unsigned LINE_DEPTH_DEF = 32;

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned ERR_W  = 8;

    // Input beat layout.
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 3;

endpackage : ual_pkg

`default_nettype wire

// ===== src/ual_line_mem.sv =====
// Line store of the UART line assembler: one write port, one registered read port.
// Depends on ual_pkg.
`default_nettype none

module ual_line_mem #(
    parameter int unsigned LINE_DEPTH = ual_pkg::LINE_DEPTH_DEF,
    parameter int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  wire                          aclk,
    input  wire                          wr_en,
    input  wire [ADDR_W-1:0]             wr_addr,
    input  wire [ual_pkg::BYTE_W-1:0]    wr_data,
    input  wire                          rd_en,
    input  wire [ADDR_W-1:0]             rd_addr,
    output logic [ual_pkg::BYTE_W-1:0]   rd_data
);
    import ual_pkg::*;

    logic [BYTE_W-1:0] store_mem [LINE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= store_mem[rd_addr];
        end
    end

endmodule : ual_line_mem

`default_nettype wire

// ===== src/uart_line_assembler.sv =====
// Top level of the UART line assembler: stream ports, line state and result stage.
// Depends on ual_pkg and ual_line_mem.
//
// An accepted input beat gives its result beat on m_ in the cycle after.
// Throughput: one beat per cycle; the single read port of the line store and
//   the one-deep result stage set that figure, and s_tready stays high while
//   the result stage is empty or being drained.
// Reset (aresetn low, synchronous): position 0, accepting on, error count 0,
//   event clear, result stage empty. Line store contents stay undefined.
`default_nettype none

module uart_line_assembler #(
    parameter int unsigned LINE_DEPTH = ual_pkg::LINE_DEPTH_DEF,
    parameter int unsigned POS_W      = $clog2(LINE_DEPTH + 1),
    parameter int unsigned M_BITS     = 18 + POS_W,
    parameter int unsigned M_TDATA_W  = ((M_BITS + 7) / 8) * 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input channel
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [ual_pkg::S_TDATA_W-1:0]     s_tdata,  // rx_byte[7:0], read_index[12:8], zero pad
    input  wire [ual_pkg::S_TUSER_W-1:0]     s_tuser,  // op[1:0], rx_fault[2]
    // result channel
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [M_TDATA_W-1:0]             m_tdata,  // event_flag, line_length, accepting,
                                                       // error_count, read_byte, zero pad
    output logic                             m_tlast   // line_done
);
    import ual_pkg::*;

    localparam int unsigned ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // ---------------------------------------------------------------
    // Input unpack
    // ---------------------------------------------------------------
    logic                 s_acc;
    ual_op_t              in_op;
    logic [BYTE_W-1:0]    in_byte;
    logic                 in_fault;
    logic [IDX_W-1:0]     in_idx;

    assign in_op    = ual_op_t'(s_tuser[1:0]);
    assign in_fault = s_tuser[2];
    assign in_byte  = s_tdata[7:0];
    assign in_idx   = s_tdata[8 +: IDX_W];

    // Result stage is the only buffer; it frees when drained this cycle.
    assign s_tready = !m_tvalid || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Line state
    // ---------------------------------------------------------------
    logic [POS_W-1:0]  wpos_reg,   wpos_next;
    logic              accept_reg, accept_next;
    logic [ERR_W-1:0]  err_reg,    err_next;
    logic              event_reg,  event_next;
    logic              done_reg,   done_next;
    logic              rd_en_reg,  rd_en_next;
    logic              out_vld_reg;

    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic              room;

    assign room      = (32'(wpos_reg) < LINE_DEPTH);
    assign mem_raddr = ADDR_W'(in_idx);

    always_comb begin
        wpos_next   = wpos_reg;
        accept_next = accept_reg;
        err_next    = err_reg;
        event_next  = event_reg;
        done_next   = 1'b0;
        rd_en_next  = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = in_byte;
        mem_re      = 1'b0;

        case (in_op)
            OP_RX_BYTE: begin
                if (!in_fault && in_byte != CH_LF) begin
                    if (accept_reg && err_reg == '0 && room) begin
                        mem_we = s_acc;
                        if (in_byte == CH_CR) begin
                            // terminate the line, hold it for the host
                            mem_wdata   = '0;
                            accept_next = 1'b0;
                            done_next   = 1'b1;
                            event_next  = 1'b1;
                        end else begin
                            wpos_next = wpos_reg + POS_W'(1);
                        end
                    end else begin
                        // input closed, overrun or error run; CR ends it
                        wpos_next = '0;
                        if (in_byte == CH_CR) begin
                            err_next    = '0;
                            accept_next = 1'b1;
                        end else begin
                            err_next = err_reg + ERR_W'(1);
                        end
                    end
                end
            end
            OP_RELEASE: begin
                wpos_next   = '0;
                accept_next = 1'b1;
            end
            OP_READ: begin
                rd_en_next = (32'(in_idx) < LINE_DEPTH);
                mem_re     = s_acc && rd_en_next;
            end
            OP_CLR_EVT: begin
                event_next = 1'b0;
            end
            default: begin
                event_next = event_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg    <= '0;
            accept_reg  <= 1'b1;
            err_reg     <= '0;
            event_reg   <= 1'b0;
            done_reg    <= 1'b0;
            rd_en_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                wpos_reg   <= wpos_next;
                accept_reg <= accept_next;
                err_reg    <= err_next;
                event_reg  <= event_next;
                done_reg   <= done_next;
                rd_en_reg  <= rd_en_next;
            end
            if (s_acc) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    ual_line_mem #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wpos_reg[ADDR_W-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Result beat: state registers reflect the last accepted beat
    // ---------------------------------------------------------------
    logic [BYTE_W-1:0] rd_byte;
    assign rd_byte = rd_en_reg ? mem_rdata : '0;

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = M_TDATA_W'({rd_byte, err_reg, accept_reg, wpos_reg, event_reg});

`ifndef SYNTHESIS
    // A completed line leaves the event set and input closed.
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (event_reg && !accept_reg))
        else $error("line done without event/closed state");

    // Position never passes the buffer depth.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wpos_reg) <= LINE_DEPTH)
        else $error("write position out of range");

    // An error run always has the position cleared.
    a_err_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != '0) |-> (wpos_reg == '0))
        else $error("errors pending with nonzero position");

    // A faulty byte leaves the line state untouched.
    a_fault_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_op == OP_RX_BYTE && in_fault) |=>
            (wpos_reg == $past(wpos_reg) && err_reg == $past(err_reg)
             && accept_reg == $past(accept_reg) && !done_reg))
        else $error("faulty byte changed line state");
`endif

endmodule : uart_line_assembler

`default_nettype wire
